[sv/lkvc_pkg.sv]
package lkvc_pkg;

	localparam int KEY_W    = 16;
	localparam int VALUE_W  = 32;
	localparam int CAP_W    = 5;
	localparam int WIDE_W   = 32;
	localparam int CMP_W    = 8;

	localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
	localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

	typedef enum logic {
		ACT_GET = 1'b0,
		ACT_PUT = 1'b1
	} lkvc_action_t;

	typedef struct packed {
		lkvc_action_t              action;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] value_in;
	} lkvc_req_t;

	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] read_value;
		logic                      evicted;
		logic [KEY_W-1:0]          evicted_key;
	} lkvc_rsp_t;

	// lookup status
	typedef struct packed {
		logic hit;
		logic free_found;
		logic lru_found;
	} lkvc_look_t;

	// state update command for one item
	typedef struct packed {
		logic touch;     // make target most recent and valid
		logic wr_key;
		logic wr_value;
		logic fill_inc;  // target is a free entry
	} lkvc_upd_t;

endpackage

[sv/lkvc_ifs.sv]
interface lkvc_req_if;
	logic              valid;
	logic              ready;
	lkvc_pkg::lkvc_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lkvc_rsp_if;
	logic              valid;
	logic              ready;
	lkvc_pkg::lkvc_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lkvc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [lkvc_pkg::CAP_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/lru_key_value_cache_top.sv]
// Fully associative key/value cache, least-recently-used replacement.
// req  : one item per access: action (get or put), key, value_in.
// rsp  : one item per request: hit, read_value, evicted, evicted_key.
//        A get miss reads -1, a put reads 0.
// cfg  : capacity_in_use write, always ready; write it only while idle.
//        0 acts as 1, values above CAPACITY act as CAPACITY.
// Items wait in the input register until the result slot frees.
// Throughput: one item per cycle while rsp is taken; all entries are compared
// in parallel and the recency ranks update in the same cycle the result is
// registered. A stalled rsp holds its result; one more item waits in the input
// register, after which req.ready drops until rsp is taken.
// Reset empties the cache (all entries invalid, ranks and fill cleared) and
// sets capacity_in_use to 16. No clearing pass is needed.
module lru_key_value_cache_top #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32
) (
	input logic      clk,
	input logic      arst_n,
	lkvc_req_if.sink   req,
	lkvc_rsp_if.source rsp,
	lkvc_cfg_if.sink   cfg
);

	localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = lkvc_pkg::CMP_W;

	lkvc_pkg::lkvc_req_t       req_s1;
	logic                      req_valid_s1;
	lkvc_pkg::lkvc_rsp_t       rsp_q;
	logic                      rsp_valid_q;
	logic [lkvc_pkg::CAP_W-1:0] cap_q;

	logic                      advance;
	logic [lkvc_pkg::WIDE_W-1:0] key_wide;
	logic [KEY_BITS-1:0]       key_used;

	logic [KEY_BITS-1:0]       keys [CAPACITY];
	logic [VALUE_BITS-1:0]     values [CAPACITY];
	logic [RW-1:0]             ranks [CAPACITY];
	logic [CAPACITY-1:0]       valid;
	logic [FW-1:0]             fill;

	logic [CAPACITY-1:0]       match_oh;
	logic [CAPACITY-1:0]       free_oh;
	logic [CAPACITY-1:0]       lru_oh;
	lkvc_pkg::lkvc_look_t      look;

	lkvc_pkg::lkvc_upd_t       upd;
	lkvc_pkg::lkvc_upd_t       upd_gated;
	logic [CAPACITY-1:0]       tgt_oh;
	lkvc_pkg::lkvc_rsp_t       rsp_d;

	logic [VALUE_BITS-1:0]     value_sel;
	logic signed [VALUE_BITS-1:0] value_sel_s;
	logic [KEY_BITS-1:0]       lru_key;
	logic [lkvc_pkg::WIDE_W-1:0] lru_key_wide;
	logic [CW-1:0]             cap_eff;
	logic                      room;

	// handshake: the input register moves on whenever the result slot frees
	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !req_valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
			cap_q        <= lkvc_pkg::CAP_RESET;
		end else begin
			if (req.ready) begin
				req_valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign key_wide = lkvc_pkg::WIDE_W'(req_s1.key);
	assign key_used = key_wide[KEY_BITS-1:0];

	lkvc_lookup #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.RW       (RW),
		.FW       (FW)
	) u_lookup (
		.key      (key_used),
		.keys     (keys),
		.ranks    (ranks),
		.valid    (valid),
		.fill     (fill),
		.match_oh (match_oh),
		.free_oh  (free_oh),
		.lru_oh   (lru_oh),
		.look     (look)
	);

	always_comb begin
		value_sel = '0;
		lru_key   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			value_sel = value_sel | (values[i] & {VALUE_BITS{match_oh[i]}});
			lru_key   = lru_key | (keys[i] & {KEY_BITS{lru_oh[i]}});
		end
	end

	assign value_sel_s  = value_sel;
	assign lru_key_wide = lkvc_pkg::WIDE_W'(lru_key);

	always_comb begin
		priority if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (CW'(cap_q) > CW'(CAPACITY)) begin
			cap_eff = CW'(CAPACITY);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end

	assign room = CW'(fill) < cap_eff;

	always_comb begin
		upd               = '0;
		tgt_oh            = match_oh;
		rsp_d.hit         = look.hit;
		rsp_d.read_value  = '0;
		rsp_d.evicted     = 1'b0;
		rsp_d.evicted_key = '0;
		unique case (req_s1.action)
			lkvc_pkg::ACT_GET: begin
				if (look.hit) begin
					rsp_d.read_value = lkvc_pkg::VALUE_W'(value_sel_s);
					upd.touch        = 1'b1;
				end else begin
					rsp_d.read_value = lkvc_pkg::MISS_VALUE;
				end
			end
			lkvc_pkg::ACT_PUT: begin
				upd.touch    = 1'b1;
				upd.wr_value = 1'b1;
				priority if (look.hit) begin
					tgt_oh = match_oh;
				end else if (room) begin
					tgt_oh       = free_oh;
					upd.wr_key   = 1'b1;
					upd.fill_inc = 1'b1;
				end else begin
					// full: replace the least recent entry
					tgt_oh            = lru_oh;
					upd.wr_key        = 1'b1;
					rsp_d.evicted     = 1'b1;
					rsp_d.evicted_key = lru_key_wide[lkvc_pkg::KEY_W-1:0];
				end
			end
			default: begin
				upd = '0;
			end
		endcase
	end

	assign upd_gated = advance ? upd : '0;

	lkvc_entries #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS),
		.RW         (RW),
		.FW         (FW)
	) u_entries (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd_gated),
		.tgt_oh   (tgt_oh),
		.key_wr   (key_used),
		.value_wr (req_s1.value_in[VALUE_BITS-1:0]),
		.keys     (keys),
		.values   (values),
		.ranks    (ranks),
		.valid    (valid),
		.fill     (fill)
	);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef ASSERT_OFF
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid) == int'(fill))
		else $error("fill count disagrees with valid entries");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_oh) && !(look.hit && (match_oh == '0)))
		else $error("key match is not unique");

	a_insert_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		upd_gated.fill_inc |-> look.free_found && $onehot(free_oh))
		else $error("insert without a free entry");

	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && rsp_d.evicted) |-> look.lru_found && !look.hit)
		else $error("eviction without a least recent entry");
`endif

endmodule

[sv/lkvc_lookup.sv]
module lkvc_lookup #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 16,
	parameter int RW       = 4,
	parameter int FW       = 5
) (
	input  logic [KEY_BITS-1:0] key,
	input  logic [KEY_BITS-1:0] keys [CAPACITY],
	input  logic [RW-1:0]       ranks [CAPACITY],
	input  logic [CAPACITY-1:0] valid,
	input  logic [FW-1:0]       fill,
	output logic [CAPACITY-1:0] match_oh,
	output logic [CAPACITY-1:0] free_oh,
	output logic [CAPACITY-1:0] lru_oh,
	output lkvc_pkg::lkvc_look_t look
);

	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] lru_vec;
	logic [FW-1:0]       oldest;

	assign oldest = fill - FW'(1);

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match_vec[i] = valid[i] && (keys[i] == key);
			// valid ranks are always 0 .. fill-1, so the oldest holds fill-1
			lru_vec[i]   = valid[i] && (FW'(ranks[i]) == oldest);
		end
	end

	// lowest set bit of each vector
	assign match_oh = match_vec & (~match_vec + CAPACITY'(1));
	assign free_oh  = ~valid & (valid + CAPACITY'(1));
	assign lru_oh   = lru_vec & (~lru_vec + CAPACITY'(1));

	assign look.hit        = |match_vec;
	assign look.free_found = ~&valid;
	assign look.lru_found  = |lru_vec;

endmodule

[sv/lkvc_entries.sv]
module lkvc_entries #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32,
	parameter int RW         = 4,
	parameter int FW         = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkvc_pkg::lkvc_upd_t   upd,
	input  logic [CAPACITY-1:0]   tgt_oh,
	input  logic [KEY_BITS-1:0]   key_wr,
	input  logic [VALUE_BITS-1:0] value_wr,
	output logic [KEY_BITS-1:0]   keys [CAPACITY],
	output logic [VALUE_BITS-1:0] values [CAPACITY],
	output logic [RW-1:0]         ranks [CAPACITY],
	output logic [CAPACITY-1:0]   valid,
	output logic [FW-1:0]         fill
);

	logic [KEY_BITS-1:0]   key_q   [CAPACITY];
	logic [VALUE_BITS-1:0] value_q [CAPACITY];
	logic [RW-1:0]         rank_q  [CAPACITY];
	logic [CAPACITY-1:0]   valid_q;
	logic [FW-1:0]         fill_q;
	logic [RW-1:0]         tgt_rank;
	logic [FW-1:0]         thresh;

	always_comb begin
		tgt_rank = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tgt_rank = tgt_rank | (rank_q[i] & {RW{tgt_oh[i]}});
		end
	end

	// an insert ages every valid entry, a promote only those younger than the target
	assign thresh = upd.fill_inc ? fill_q : FW'(tgt_rank);

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (tgt_oh[i] && upd.wr_key) begin
				key_q[i] <= key_wr;
			end
			if (tgt_oh[i] && upd.wr_value) begin
				value_q[i] <= value_wr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (upd.touch) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (tgt_oh[i]) begin
					rank_q[i]  <= '0;
					valid_q[i] <= 1'b1;
				end else if (valid_q[i] && (FW'(rank_q[i]) < thresh)) begin
					rank_q[i] <= rank_q[i] + RW'(1);
				end
			end
			if (upd.fill_inc) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	assign keys   = key_q;
	assign values = value_q;
	assign ranks  = rank_q;
	assign valid  = valid_q;
	assign fill   = fill_q;

endmodule

[sim/lru_key_value_cache_top_tb.sv]
module lru_key_value_cache_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = 16;
	localparam int HOLD_LONG = 120;

	typedef enum {RX_FREE, RX_COIN, RX_PATTERN} rx_mode_t;

	logic clk;
	logic arst_n;

	lkvc_req_if req_ch ();
	lkvc_rsp_if rsp_ch ();
	lkvc_cfg_if cfg_ch ();

	lru_key_value_cache_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow copy of the cache contents
	logic [lkvc_pkg::KEY_W-1:0]          slot_key  [SLOTS] = '{default: '0};
	logic signed [lkvc_pkg::VALUE_W-1:0] slot_val  [SLOTS] = '{default: '0};
	bit                                  slot_live [SLOTS] = '{default: 1'b0};
	int                                  slot_rank [SLOTS] = '{default: 0};
	int                                  held    = 0;
	logic [lkvc_pkg::CAP_W-1:0]          cap_reg = lkvc_pkg::CAP_RESET;

	lkvc_pkg::lkvc_req_t req_backlog [$];
	lkvc_pkg::lkvc_rsp_t awaited_rsp [$];

	int error_count = 0;
	bit req_fire    = 1'b0;
	int cfg_seen    = 0;
	int gap_left    = 0;
	int burst_left  = 1;
	int stall_asked = 0;
	int stall_done  = 0;
	int hold_left   = 0;
	int mode_left   = 0;
	rx_mode_t rx_mode = RX_FREE;
	logic [31:0] rx_pattern = '1;

	function automatic int eff_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > SLOTS)
			return SLOTS;
		return int'(c);
	endfunction

	// entries younger than e age by one, e becomes newest
	function automatic void make_newest(int e);
		int i;
		for (i = 0; i < SLOTS; i++)
			if (slot_live[i] && slot_rank[i] < slot_rank[e])
				slot_rank[i]++;
		slot_rank[e] = 0;
	endfunction

	function automatic lkvc_pkg::lkvc_rsp_t cache_access(lkvc_pkg::lkvc_req_t r);
		lkvc_pkg::lkvc_rsp_t o;
		int i;
		int found;
		int slot;
		o = '0;
		found = -1;
		for (i = 0; i < SLOTS; i++)
			if (found < 0 && slot_live[i] && slot_key[i] == r.key)
				found = i;
		o.hit = (found >= 0);
		if (r.action == lkvc_pkg::ACT_GET) begin
			if (found >= 0) begin
				o.read_value = slot_val[found];
				make_newest(found);
			end else begin
				o.read_value = lkvc_pkg::MISS_VALUE;
			end
		end else if (found >= 0) begin
			slot_val[found] = r.value_in;
			make_newest(found);
		end else if (held < eff_capacity(cap_reg)) begin
			slot = -1;
			for (i = 0; i < SLOTS; i++)
				if (slot < 0 && !slot_live[i])
					slot = i;
			if (slot >= 0) begin
				for (i = 0; i < SLOTS; i++)
					if (slot_live[i])
						slot_rank[i]++;
				slot_live[slot] = 1'b1;
				slot_key[slot]  = r.key;
				slot_val[slot]  = r.value_in;
				slot_rank[slot] = 0;
				held++;
			end
		end else begin
			// replace the oldest entry; capacity may sit below the fill
			slot = -1;
			for (i = 0; i < SLOTS; i++)
				if (slot_live[i] && (slot < 0 || slot_rank[i] > slot_rank[slot]))
					slot = i;
			if (slot >= 0) begin
				o.evicted     = 1'b1;
				o.evicted_key = slot_key[slot];
				slot_key[slot] = r.key;
				slot_val[slot] = r.value_in;
				make_newest(slot);
			end
		end
		return o;
	endfunction

	function automatic lkvc_pkg::lkvc_req_t req_item(lkvc_pkg::lkvc_action_t act,
			logic [lkvc_pkg::KEY_W-1:0] k, logic signed [lkvc_pkg::VALUE_W-1:0] v);
		lkvc_pkg::lkvc_req_t a;
		a.action   = act;
		a.key      = k;
		a.value_in = v;
		return a;
	endfunction

	// keys mostly from a window a little wider than the capacity, so hits,
	// updates and evictions all happen often
	function automatic lkvc_pkg::lkvc_req_t make_access(logic [lkvc_pkg::KEY_W-1:0] base,
			int span);
		lkvc_pkg::lkvc_req_t a;
		int pick;
		a.action = ($urandom_range(0, 99) < 55) ? lkvc_pkg::ACT_PUT : lkvc_pkg::ACT_GET;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			a.key = base + 16'($urandom_range(0, span - 1));
		else if (pick < 96)
			a.key = 16'($urandom);
		else
			a.key = pick[0] ? '1 : '0;
		case ($urandom_range(0, 9))
			0: a.value_in = 32'sh7FFFFFFF;
			1: a.value_in = 32'sh80000000;
			2: a.value_in = '0;
			3: a.value_in = lkvc_pkg::MISS_VALUE;
			default: a.value_in = $urandom;
		endcase
		return a;
	endfunction

	// look just after the falling edge, once the driver's updates have landed
	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (req_backlog.size() != 0 || req_ch.valid || awaited_rsp.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
		int seen;
		seen = cfg_seen;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= c;
		do
			@(negedge clk);
		while (cfg_seen == seen);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(logic [lkvc_pkg::CAP_W-1:0] c, int n, bit long_hold);
		logic [lkvc_pkg::KEY_W-1:0] base;
		int span;
		int k;
		wait_idle();
		write_capacity(c);
		base = 16'($urandom);
		span = eff_capacity(c) + $urandom_range(0, 6);
		if (long_hold)
			stall_asked++;
		for (k = 0; k < n; k++)
			req_backlog.push_back(make_access(base, span));
		wait_idle();
	endtask

	initial begin
		clk    = 1'b0;
		arst_n = 1'b0;
		fork
			forever #6 clk = ~clk;
		join_none
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
	end

	// item driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				req_ch.data  <= req_backlog.pop_front();
				req_ch.valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result ready: long hold on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (stall_done != stall_asked) begin
			stall_done++;
			hold_left = HOLD_LONG;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode    = rx_mode_t'($urandom_range(0, 2));
				mode_left  = $urandom_range(8, 64);
				rx_pattern = $urandom;
			end
			mode_left--;
			case (rx_mode)
				RX_FREE: rsp_ch.ready <= 1'b1;
				RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default: begin
					rsp_ch.ready <= rx_pattern[0];
					rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
				end
			endcase
		end
	end

	// monitor: check results, predict accepted items, track the register
	always @(posedge clk) begin
		lkvc_pkg::lkvc_rsp_t want;
		lkvc_pkg::lkvc_rsp_t got;
		if (arst_n) begin
			req_fire = req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (awaited_rsp.size() == 0) begin
					error_count++;
					$display("%0t ns: unexpected result, expected none, actual %h", $time, got);
				end else begin
					want = awaited_rsp.pop_front();
					if (got.hit !== want.hit) begin
						error_count++;
						$display("%0t ns: hit mismatch, expected %b, actual %b",
							$time, want.hit, got.hit);
					end
					if (got.read_value !== want.read_value) begin
						error_count++;
						$display("%0t ns: read_value mismatch, expected %h, actual %h",
							$time, want.read_value, got.read_value);
					end
					if (got.evicted !== want.evicted) begin
						error_count++;
						$display("%0t ns: evicted mismatch, expected %b, actual %b",
							$time, want.evicted, got.evicted);
					end
					if (got.evicted_key !== want.evicted_key) begin
						error_count++;
						$display("%0t ns: evicted_key mismatch, expected %h, actual %h",
							$time, want.evicted_key, got.evicted_key);
					end
				end
			end
			if (req_fire)
				awaited_rsp.push_back(cache_access(req_ch.data));
			if (cfg_ch.valid && cfg_ch.ready) begin
				cap_reg = cfg_ch.data;
				cfg_seen++;
			end
		end
	end

	initial begin
		int p;
		logic [lkvc_pkg::CAP_W-1:0] caps [7];
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		caps = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd8, 5'd16};
		@(posedge arst_n);

		// empty cache, reset capacity
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h0000, 32'sh0));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'h0000, 32'sh7FFFFFFF));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'hFFFF, 32'sh80000000));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'hFFFF, 32'sh12345678));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h0000, 32'sh0));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'h0000, lkvc_pkg::MISS_VALUE));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h0000, 32'sh0));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h1234, 32'sh0));
		wait_idle();

		// zero acts as one; capacity now below the fill
		write_capacity(5'd0);
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'h0001, 32'sh1));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'h0002, 32'sh2));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h0001, 32'sh0));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'hFFFF, 32'sh0));
		wait_idle();

		// above the entry count acts as the entry count
		write_capacity(5'd31);
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'h0003, 32'sh3));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'h0004, -32'sh4));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h0002, 32'sh0));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'hAAAA, 32'sh55555555));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h5555, 32'sh0));
		wait_idle();

		write_capacity(5'd1);
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'h0007, 32'sh7));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h0007, 32'sh0));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_PUT, 16'h0007, 32'shCAFEF00D));
		req_backlog.push_back(req_item(lkvc_pkg::ACT_GET, 16'h0003, 32'sh0));

		for (p = 0; p < 12; p++)
			run_phase(p < 7 ? caps[p] : 5'($urandom_range(0, 31)), 150,
				p == 1 || p == 6 || $urandom_range(0, 3) == 0);

		wait_idle();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
sv/lkvc_pkg.sv
sv/lkvc_ifs.sv
sv/lkvc_lookup.sv
sv/lkvc_entries.sv
sv/lru_key_value_cache_top.sv
sim/lru_key_value_cache_top_tb.sv
